[design/cdzd_pkg.sv]
// Package for the columnar delta/zigzag decoder: widths, configuration indexes,
// lane control and result types, and the zigzag decode function.
// No dependencies.
package cdzd_pkg;

    localparam int LANES  = 5;
    localparam int DATA_W = 64;
    localparam int WIN_W  = 63;
    localparam int CNT_W  = 3;
    localparam int MASK_W = 5;
    localparam int IDX_W  = 2;

    localparam logic [CNT_W-1:0]  COL_COUNT_RST    = 3'd3;
    localparam logic [MASK_W-1:0] SIGNED_MASK_RST  = 5'd0;
    localparam logic [WIN_W-1:0]  WINDOW_START_RST = '0;
    localparam logic [WIN_W-1:0]  WINDOW_END_RST   = '1;

    typedef enum logic [IDX_W-1:0] {
        CFG_COL_COUNT    = 2'd0,
        CFG_SIGNED_MASK  = 2'd1,
        CFG_WINDOW_START = 2'd2,
        CFG_WINDOW_END   = 2'd3
    } cfg_index_t;

    typedef enum logic {
        FUNC_BASE  = 1'b0,
        FUNC_DELTA = 1'b1
    } func_t;

    typedef struct packed {
        logic accept;
        logic base;
        logic active;
        logic zigzag;
    } lane_ctl_t;

    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] values;
        logic                         emitted;
        logic                         beyond_end;
    } result_t;

    function automatic logic [DATA_W-1:0] unzigzag(input logic [DATA_W-1:0] raw);
        return (raw >> 1) ^ {DATA_W{raw[0]}};
    endfunction

endpackage

[design/cdzd_lane.sv]
// One column lane: holds the running value of its column and applies a base
// load or a plain or zigzag delta. Depends on cdzd_pkg.
module cdzd_lane
    import cdzd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctl_t         ctl,
    input  logic [DATA_W-1:0] raw,
    output logic [DATA_W-1:0] value_next
);

    logic [DATA_W-1:0] running_reg;
    logic [DATA_W-1:0] delta;

    assign delta = ctl.zigzag ? unzigzag(raw) : raw;

    always_comb
    begin
        if (ctl.base)
        begin
            value_next = ctl.active ? raw : '0;
        end
        else if (ctl.active)
        begin
            value_next = running_reg + delta;
        end
        else
        begin
            value_next = running_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
        end
        else if (ctl.accept)
        begin
            running_reg <= value_next;
        end
    end

`ifndef SYNTHESIS
    // A base item clears a column that is not active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && ctl.base && !ctl.active) |=> (running_reg == '0))
        else $error("inactive lane not cleared by base item");

    // A delta item leaves an inactive column untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && !ctl.base && !ctl.active) |=> $stable(running_reg))
        else $error("inactive lane changed by delta item");
`endif

endmodule

[design/cdzd_merge.sv]
// Merging stage: masks the lane values, computes the window flags from the
// timestamp lane, and holds results in an output register with a skid entry.
// Depends on cdzd_pkg.
module cdzd_merge
    import cdzd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [LANES-1:0]             active,
    input  logic [LANES-1:0][DATA_W-1:0] lane_next,
    input  logic [WIN_W-1:0]             window_start,
    input  logic [WIN_W-1:0]             window_end,
    input  logic                         out_stall,
    output logic                         in_stall,
    output logic                         out_valid,
    output result_t                      result
);

    result_t result_next;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    take;
    logic    at_or_past_end;
    logic    at_or_past_start;

    assign at_or_past_start = lane_next[0] >= {1'b0, window_start};
    assign at_or_past_end   = lane_next[0] >= {1'b0, window_end};

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            result_next.values[j] = active[j] ? lane_next[j] : '0;
        end
        result_next.emitted    = at_or_past_start && !at_or_past_end;
        result_next.beyond_end = at_or_past_end;
    end

    assign take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= result_next;
            end
            else
            begin
                skid_reg <= result_next;
            end
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

`ifndef SYNTHESIS
    // The skid entry is only ever used behind a held output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output entry");

    // An item accepted behind a stalled result lands in the skid entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("item accepted behind stalled result was lost");

    // The two window flags never hold together.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.emitted && out_reg.beyond_end))
        else $error("emitted and beyond_end both set");
`endif

endmodule

[design/columnar_delta_zigzag_decoder_core.sv]
// Results are registered in the merge stage's output register or skid entry.
// Throughput: one item per cycle while in_stall is low, set by the per-column
// 64-bit adder and timestamp window compare; a two-entry output absorbs stalls.
// Reset clears the running column values to zero and loads the configuration
// registers with their defaults; no clearing pass is needed.
// Depends on cdzd_pkg, cdzd_lane and cdzd_merge.
module columnar_delta_zigzag_decoder_core
    import cdzd_pkg::*;
#(
    parameter int COLUMNS = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [WIN_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [DATA_W-1:0] d0,
    input  logic [DATA_W-1:0] d1,
    input  logic [DATA_W-1:0] d2,
    input  logic [DATA_W-1:0] d3,
    input  logic [DATA_W-1:0] d4,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] v0,
    output logic [DATA_W-1:0] v1,
    output logic [DATA_W-1:0] v2,
    output logic [DATA_W-1:0] v3,
    output logic [DATA_W-1:0] v4,
    output logic              emitted,
    output logic              beyond_end
);

    localparam logic [CNT_W-1:0] COL_MAX = CNT_W'(COLUMNS);

    logic [CNT_W-1:0]             col_count_reg;
    logic [MASK_W-1:0]            signed_mask_reg;
    logic [WIN_W-1:0]             window_start_reg;
    logic [WIN_W-1:0]             window_end_reg;
    logic [CNT_W-1:0]             count_eff;
    logic [LANES-1:0]             active;
    logic [LANES-1:0][DATA_W-1:0] raw;
    logic [LANES-1:0][DATA_W-1:0] lane_next;
    logic                         accept;
    result_t                      result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg    <= COL_COUNT_RST;
            signed_mask_reg  <= SIGNED_MASK_RST;
            window_start_reg <= WINDOW_START_RST;
            window_end_reg   <= WINDOW_END_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COL_COUNT:    col_count_reg    <= cfg_data[CNT_W-1:0];
                CFG_SIGNED_MASK:  signed_mask_reg  <= cfg_data[MASK_W-1:0];
                CFG_WINDOW_START: window_start_reg <= cfg_data;
                CFG_WINDOW_END:   window_end_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // A count of zero still decodes the timestamp column.
    always_comb
    begin
        priority if (col_count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (col_count_reg > COL_MAX)
        begin
            count_eff = COL_MAX;
        end
        else
        begin
            count_eff = col_count_reg;
        end
    end

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            active[j] = CNT_W'(j) < count_eff;
        end
    end

    assign accept = in_valid && !in_stall;
    assign raw    = {d4, d3, d2, d1, d0};

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        if (j < COLUMNS)
        begin : g_used
            lane_ctl_t ctl;

            assign ctl.accept = accept;
            assign ctl.base   = func == FUNC_BASE;
            assign ctl.active = active[j];
            assign ctl.zigzag = signed_mask_reg[j];

            cdzd_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .raw        (raw[j]),
                .value_next (lane_next[j])
            );
        end
        else
        begin : g_unused
            assign lane_next[j] = '0;
        end
    end

    cdzd_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .active       (active),
        .lane_next    (lane_next),
        .window_start (window_start_reg),
        .window_end   (window_end_reg),
        .out_stall    (out_stall),
        .in_stall     (in_stall),
        .out_valid    (out_valid),
        .result       (result)
    );

    assign v0         = result.values[0];
    assign v1         = result.values[1];
    assign v2         = result.values[2];
    assign v3         = result.values[3];
    assign v4         = result.values[4];
    assign emitted    = result.emitted;
    assign beyond_end = result.beyond_end;

`ifndef SYNTHESIS
    // The timestamp column is always active.
    assert property (@(posedge clk) disable iff (!rst_n)
        active[0] && (count_eff <= COL_MAX))
        else $error("active column count out of range");
`endif

endmodule

[tb/sv/cdzd_tb_pkg.sv]
`timescale 1ns / 1ps
// Record scoreboard for the columnar delta/zigzag decoder testbench. It predicts each
// decoded record from the accepted items and checks the block's results in order.
// Depends on cdzd_pkg.
package cdzd_tb_pkg;
    import cdzd_pkg::*;

    class record_scoreboard;
        logic [CNT_W-1:0]  col_count;
        logic [MASK_W-1:0] signed_mask;
        logic [WIN_W-1:0]  window_start;
        logic [WIN_W-1:0]  window_end;
        logic [DATA_W-1:0] column_sum [LANES];
        result_t           expected_records [$];
        int                items_seen;
        int                records_seen;
        int                inside_seen;
        int                past_seen;
        int                errors;

        function new();
            col_count    = COL_COUNT_RST;
            signed_mask  = SIGNED_MASK_RST;
            window_start = WINDOW_START_RST;
            window_end   = WINDOW_END_RST;
            foreach (column_sum[j])
                column_sum[j] = '0;
            items_seen   = 0;
            records_seen = 0;
            inside_seen  = 0;
            past_seen    = 0;
            errors       = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 40)
                $display("error: %s", msg);
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function void write_reg(cfg_index_t idx, logic [WIN_W-1:0] value);
            case (idx)
                CFG_COL_COUNT:    col_count    = value[CNT_W-1:0];
                CFG_SIGNED_MASK:  signed_mask  = value[MASK_W-1:0];
                CFG_WINDOW_START: window_start = value;
                CFG_WINDOW_END:   window_end   = value;
                default:          ;
            endcase
        endfunction

        function void predict_record(func_t op, logic [LANES-1:0][DATA_W-1:0] raw);
            int                active;
            logic [DATA_W-1:0] step;
            logic [DATA_W-1:0] stamp;
            result_t           rec;
            // A column count of zero still decodes the timestamp; larger counts saturate.
            active = (col_count == 0) ? 1 : int'(col_count);
            if (active > LANES)
                active = LANES;
            rec = '0;
            for (int j = 0; j < LANES; j++)
            begin
                if (j >= active)
                begin
                    if (op == FUNC_BASE)
                        column_sum[j] = '0;
                end
                else if (op == FUNC_BASE)
                    column_sum[j] = raw[j];
                else
                begin
                    step = raw[j];
                    if (signed_mask[j])
                        step = (raw[j] >> 1) ^ (DATA_W'(0) - DATA_W'(raw[j][0]));
                    column_sum[j] = column_sum[j] + step;
                end
                if (j < active)
                    rec.values[j] = column_sum[j];
            end
            stamp = column_sum[0];
            rec.emitted    = (stamp >= {1'b0, window_start}) && (stamp < {1'b0, window_end});
            rec.beyond_end = (stamp >= {1'b0, window_end});
            expected_records.push_back(rec);
            items_seen++;
        endfunction

        function void check_record(result_t got);
            result_t want;
            if (expected_records.size() == 0)
            begin
                report("result arrived with no item pending");
                return;
            end
            want = expected_records.pop_front();
            records_seen++;
            if (want.emitted)
                inside_seen++;
            if (want.beyond_end)
                past_seen++;
            for (int j = 0; j < LANES; j++)
            begin
                if (got.values[j] !== want.values[j])
                    report($sformatf("record %0d: v%0d is %h, expected %h",
                        records_seen, j, got.values[j], want.values[j]));
            end
            if (got.emitted !== want.emitted)
                report($sformatf("record %0d: emitted is %b, expected %b",
                    records_seen, got.emitted, want.emitted));
            if (got.beyond_end !== want.beyond_end)
                report($sformatf("record %0d: beyond_end is %b, expected %b",
                    records_seen, got.beyond_end, want.beyond_end));
        endfunction
    endclass

endpackage

[tb/sv/tb_columnar_delta_zigzag_decoder_core.sv]
`timescale 1ns / 1ps
// Top of the columnar delta/zigzag decoder testbench: clock, reset, item and
// configuration drivers, result monitor and the phased stimulus.
// Depends on cdzd_pkg, cdzd_tb_pkg and the decoder RTL.
module tb_columnar_delta_zigzag_decoder_core;
    import cdzd_pkg::*;
    import cdzd_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [DATA_W-1:0] ONES = '1;
    localparam logic [DATA_W-1:0] TOP  = 64'h8000_0000_0000_0000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [WIN_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              func;
    logic [DATA_W-1:0] d0;
    logic [DATA_W-1:0] d1;
    logic [DATA_W-1:0] d2;
    logic [DATA_W-1:0] d3;
    logic [DATA_W-1:0] d4;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] v0;
    logic [DATA_W-1:0] v1;
    logic [DATA_W-1:0] v2;
    logic [DATA_W-1:0] v3;
    logic [DATA_W-1:0] v4;
    logic              emitted;
    logic              beyond_end;

    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               cycle_count    = 0;
    int               hold_count;
    bit               hold_request   = 1'b0;
    logic [WIN_W-1:0] cur_start      = WINDOW_START_RST;
    record_scoreboard records        = new();

    columnar_delta_zigzag_decoder_core u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d records outstanding.",
                cycle_count, records.pending());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t seen;
        if (rst_n && in_valid && !in_stall)
            records.predict_record(func_t'(func), {d4, d3, d2, d1, d0});
        if (rst_n && out_valid && !out_stall)
        begin
            seen.values     = {v4, v3, v2, v1, v0};
            seen.emitted    = emitted;
            seen.beyond_end = beyond_end;
            records.check_record(seen);
        end
    end

    // The receiver stalls at random, or holds off for a long stretch on request.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'($urandom_range(255));
            3:       return {1'b1, 31'($urandom), $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] delta_word(input int small_pct);
        if ($urandom_range(99) < small_pct)
            return DATA_W'($urandom_range(64));
        return rand_word();
    endfunction

    function automatic logic [DATA_W-1:0] base_stamp();
        if ($urandom_range(9) < 6)
            return {1'b0, cur_start} + DATA_W'($urandom_range(40)) - 64'd20;
        return rand_word();
    endfunction

    task automatic send_item(input func_t op, input logic [DATA_W-1:0] a0,
        input logic [DATA_W-1:0] a1, input logic [DATA_W-1:0] a2,
        input logic [DATA_W-1:0] a3, input logic [DATA_W-1:0] a4);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        d0       <= a0;
        d1       <= a1;
        d2       <= a2;
        d3       <= a3;
        d4       <= a4;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // The extra edge lets the monitor note the last accepted item first.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (records.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [WIN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        records.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [CNT_W-1:0] ncol, input logic [MASK_W-1:0] mask,
        input logic [WIN_W-1:0] ws, input logic [WIN_W-1:0] we);
        wait_drained();
        write_reg(CFG_COL_COUNT, WIN_W'(ncol));
        write_reg(CFG_SIGNED_MASK, WIN_W'(mask));
        write_reg(CFG_WINDOW_START, ws);
        write_reg(CFG_WINDOW_END, we);
        cfg_we <= 1'b0;
        cur_start = ws;
    endtask

    task automatic run_phase(input int n_items, input logic [CNT_W-1:0] ncol,
        input logic [MASK_W-1:0] mask, input logic [WIN_W-1:0] ws, input logic [WIN_W-1:0] we,
        input int send_pct, input int recv_pct, input bit hold);
        int sent;
        int run_len;
        apply_config(ncol, mask, ws, we);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold)
            hold_request = 1'b1;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(func_t'($urandom_range(1)), rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_word());
                sent++;
            end
            else
            begin
                send_item(FUNC_BASE, base_stamp(), rand_word(), rand_word(), rand_word(),
                    rand_word());
                sent++;
                run_len = $urandom_range(12, 1);
                for (int k = 0; k < run_len && sent < n_items; k++)
                begin
                    send_item(FUNC_DELTA, delta_word(80), delta_word(50), delta_word(50),
                        delta_word(50), delta_word(50));
                    sent++;
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        logic [WIN_W-1:0] ws;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_COL_COUNT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        func      <= FUNC_BASE;
        d0        <= '0;
        d1        <= '0;
        d2        <= '0;
        d3        <= '0;
        d4        <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default settings: three columns, unsigned deltas, full window.
        send_item(FUNC_DELTA, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        send_item(FUNC_BASE, ONES, ONES, ONES, ONES, ONES);
        send_item(FUNC_DELTA, 64'd1, 64'd1, 64'd1, 64'd1, 64'd1);
        send_item(FUNC_BASE, 64'h7FFF_FFFF_FFFF_FFFE, 64'h5555_5555_5555_5555,
            64'hAAAA_AAAA_AAAA_AAAA, ONES, ONES);
        send_item(FUNC_DELTA, 64'd1, ONES, 64'd1, 64'd0, 64'd0);

        // All columns zigzag, window edges at 100 and 200.
        apply_config(3'd5, 5'h1F, 63'd100, 63'd200);
        send_item(FUNC_BASE, 64'd99, 64'd0, ONES, TOP, 64'd1);
        send_item(FUNC_DELTA, 64'd2, 64'd1, ONES, ONES - 64'd1, ONES);
        send_item(FUNC_DELTA, 64'd198, 64'd0, 64'd3, 64'd4, 64'd0);
        send_item(FUNC_DELTA, 64'd2, 64'd5, 64'd6, 64'd7, 64'd8);
        send_item(FUNC_DELTA, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0);

        // Column count zero and an inverted window.
        apply_config(3'd0, 5'b00001, 63'd500, 63'd10);
        send_item(FUNC_BASE, 64'd600, ONES, ONES, ONES, ONES);
        send_item(FUNC_DELTA, 64'd1189, ONES, ONES, ONES, ONES);
        send_item(FUNC_DELTA, 64'd0, 64'd5, 64'd6, 64'd7, 64'd8);

        // Column count above the lane count, one-wide window at zero.
        apply_config(3'd7, 5'b11110, 63'd0, 63'd1);
        send_item(FUNC_BASE, 64'd0, 64'd10, 64'd20, 64'd30, 64'd40);
        send_item(FUNC_DELTA, 64'd1, 64'd3, 64'd2, ONES, 64'd1);
        send_item(FUNC_DELTA, ONES, TOP, 64'd0, 64'd0, 64'd0);

        ws = WIN_W'({$urandom, $urandom} >> 2);
        run_phase(250, 3'd5, 5'b10101, ws, ws + 63'd200, 0, 0, 1'b0);
        run_phase(250, 3'd1, 5'h1F, '0, WINDOW_END_RST, 49, 0, 1'b0);
        ws = WIN_W'({$urandom, $urandom} >> 2);
        run_phase(250, 3'd4, MASK_W'($urandom), ws, WIN_W'({$urandom, $urandom}), 0, 49, 1'b0);
        run_phase(250, 3'd7, 5'd0, WINDOW_END_RST, 63'd1, 17, 17, 1'b0);
        run_phase(250, 3'd0, 5'h1F, 63'd1000, 63'd1000, 0, 0, 1'b0);
        ws = WIN_W'({$urandom, $urandom} >> 2);
        run_phase(250, 3'd2, MASK_W'($urandom), ws, ws + 63'd300, 49, 0, 1'b0);
        run_phase(250, 3'd6, 5'h1F, 63'd50, 63'd90, 0, 49, 1'b0);
        ws = WIN_W'({$urandom, $urandom} >> 2);
        run_phase(250, 3'd5, MASK_W'($urandom), ws, ws + 63'd100, 17, 17, 1'b0);
        run_phase(150, 3'd5, 5'b01010, ws, ws + 63'd100, 0, 0, 1'b1);

        wait_drained();
        $display("Checked %0d records from %0d items across all column counts and window shapes;",
            records.records_seen, records.items_seen);
        $display("%0d records fell inside the window, %0d at or past its end, %0d mismatches.",
            records.inside_seen, records.past_seen, records.errors);
        if (records.errors == 0 && records.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
